FILE: sv/clipped_window_median_filter_core_defines.svh
// Assertion macros shared by the median filter RTL.
`ifndef CLIPPED_WINDOW_MEDIAN_FILTER_CORE_DEFINES_SVH
`define CLIPPED_WINDOW_MEDIAN_FILTER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define CWMF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define CWMF_ASSERT_NR(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CWMF_ASSERT(lbl, prop, msg)
`define CWMF_ASSERT_NR(lbl, prop, msg)
`endif
`endif

FILE: sv/cwmf_pkg.sv
// Shared constants and types of the clipped window median filter.
`default_nettype none
package cwmf_pkg;
	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_RADIUS_DEF = 3;
	localparam int MAX_HEIGHT     = 4096;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int WIDTH_W    = 9;
	localparam int HEIGHT_W   = 13;
	localparam int RADIUS_W   = 2;
	localparam int POS_W      = 22;
	localparam int RC_W       = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd2;

	localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 9'd256;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd256;
	localparam logic [RADIUS_W-1:0] RADIUS_RST = 2'd3;

	typedef struct packed {
		logic load;
		logic start;
	} sel_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} sel_stat_t;
endpackage
`default_nettype wire

FILE: sv/cwmf_select.sv
// Window buffer and bitwise rank selection that finds the median of the gathered values.
`default_nettype none
module cwmf_select #(
	parameter int MAX_RADIUS = cwmf_pkg::MAX_RADIUS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cwmf_pkg::sel_ctrl_t ctrl,
	input  wire logic [7:0]          load_data,
	output cwmf_pkg::sel_stat_t      stat,
	output logic [7:0]               median
);
	import cwmf_pkg::*;

	localparam int WIN_MAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
	localparam int WIN_AW  = $clog2(WIN_MAX);
	localparam int WIN_CW  = $clog2(WIN_MAX + 1);

	logic [7:0]        win_mem [WIN_MAX];
	logic [WIN_CW-1:0] wcnt_q, cnt_q, ka_q, kb_q, ca_q, cb_q, ca_n, cb_n;
	logic [WIN_AW-1:0] idx_q;
	logic              issue_q, rv_s1, last_s1, busy_q, done_q;
	logic [7:0]        rdata_s1, pa_q, pb_q, pa_n, pb_n, med_q, hi_mask;
	logic [2:0]        bit_q;
	logic              zero_a, zero_b, ge_a, ge_b;
	logic [8:0]        sum;

	always_ff @(posedge clk) begin
		if (ctrl.load)
			win_mem[wcnt_q[WIN_AW-1:0]] <= load_data;
		if (issue_q)
			rdata_s1 <= win_mem[idx_q];
	end

	// A value counts toward a rank's zero side when it shares the prefix found so far
	// and has a zero at the current bit.
	always_comb begin
		hi_mask = 8'hFF << ({1'b0, bit_q} + 4'd1);
		zero_a  = ((rdata_s1 & hi_mask) == (pa_q & hi_mask)) && !rdata_s1[bit_q];
		zero_b  = ((rdata_s1 & hi_mask) == (pb_q & hi_mask)) && !rdata_s1[bit_q];
		ca_n    = ca_q + WIN_CW'(zero_a);
		cb_n    = cb_q + WIN_CW'(zero_b);
		ge_a    = ka_q >= ca_n;
		ge_b    = kb_q >= cb_n;
		pa_n    = pa_q | (8'(ge_a) << bit_q);
		pb_n    = pb_q | (8'(ge_b) << bit_q);
		sum     = {1'b0, pa_n} + {1'b0, pb_n};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcnt_q  <= '0;
			cnt_q   <= '0;
			idx_q   <= '0;
			issue_q <= 1'b0;
			rv_s1   <= 1'b0;
			last_s1 <= 1'b0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			bit_q   <= '0;
			ka_q    <= '0;
			kb_q    <= '0;
			ca_q    <= '0;
			cb_q    <= '0;
			pa_q    <= '0;
			pb_q    <= '0;
			med_q   <= '0;
		end else begin
			done_q  <= !ctrl.start && rv_s1 && last_s1 && (bit_q == 3'd0);
			rv_s1   <= issue_q;
			last_s1 <= issue_q && (idx_q == WIN_AW'(cnt_q - 1'b1));
			if (ctrl.start) begin
				cnt_q   <= wcnt_q;
				wcnt_q  <= '0;
				ka_q    <= (wcnt_q - 1'b1) >> 1;
				kb_q    <= wcnt_q >> 1;
				pa_q    <= '0;
				pb_q    <= '0;
				ca_q    <= '0;
				cb_q    <= '0;
				bit_q   <= 3'd7;
				idx_q   <= '0;
				issue_q <= 1'b1;
				busy_q  <= 1'b1;
			end else begin
				if (ctrl.load)
					wcnt_q <= wcnt_q + 1'b1;
				if (issue_q) begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == WIN_AW'(cnt_q - 1'b1))
						issue_q <= 1'b0;
				end
				if (rv_s1) begin
					if (last_s1) begin
						ca_q <= '0;
						cb_q <= '0;
						pa_q <= pa_n;
						pb_q <= pb_n;
						if (ge_a)
							ka_q <= ka_q - ca_n;
						if (ge_b)
							kb_q <= kb_q - cb_n;
						if (bit_q == 3'd0) begin
							busy_q <= 1'b0;
							med_q  <= sum[8:1];
						end else begin
							bit_q   <= bit_q - 1'b1;
							idx_q   <= '0;
							issue_q <= 1'b1;
						end
					end else begin
						ca_q <= ca_n;
						cb_q <= cb_n;
					end
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign median    = med_q;
endmodule
`default_nettype wire

FILE: sv/clipped_window_median_filter_core.sv
// Streaming clipped-window median filter: top level with row store and sequencer.
//
// Pixels enter in raster order on in_valid/in_stall with func = 0; drain requests
// (func = 1) push out the last R rows and R pixels once the frame's pixels are in.
// Each request that produces a result yields one median on out_valid/out_stall with
// its row, column and a frame_end flag; results lag the input by R rows plus R pixels.
// A request that produces a result has its median in the output register after these
// steps: a setup step, the gather of the clipped window (up to 49 values) from the row
// store, a handover, eight passes over the window buffer, one per median bit, that
// track the two middle ranks, then a finish step and the load of the output register.
// The next request is taken only once that result is in the output register.
// Requests with no result are taken without a stall.
// in_stall stays high while a request is in work and while a finished median waits
// for a stalled receiver with the output register already full.
// Configuration writes (image width, height, radius) restart the frame and must only
// happen while the block is idle. Reset sets width 256, height 256, radius 3 and the
// start of a frame; the row store needs no clearing since only written entries are read.
`default_nettype none
`include "clipped_window_median_filter_core_defines.svh"
module clipped_window_median_filter_core #(
	parameter int MAX_WIDTH  = cwmf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_RADIUS = cwmf_pkg::MAX_RADIUS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [cwmf_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  wire logic [cwmf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           func,
	input  wire logic [7:0]                     pixel_in,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [7:0]                          median_pixel,
	output logic [11:0]                         out_row,
	output logic [7:0]                          out_col,
	output logic                                frame_end
);
	import cwmf_pkg::*;

	localparam int STORE = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
	localparam int SAW   = $clog2(STORE);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SETUP  = 3'd1;
	localparam logic [2:0] ST_GATHER = 3'd2;
	localparam logic [2:0] ST_GWAIT  = 3'd3;
	localparam logic [2:0] ST_START  = 3'd4;
	localparam logic [2:0] ST_SEL    = 3'd5;
	localparam logic [2:0] ST_OUT    = 3'd6;

	logic [2:0]          state_q;
	logic [WIDTH_W-1:0]  width_q, w_eff, rt_room;
	logic [HEIGHT_W-1:0] height_q, h_eff, dn_room;
	logic [RADIUS_W-1:0] radius_q, r_eff, up, dn, lf, rt;
	logic [POS_W-1:0]    pos_q, npix, lag;
	logic [SAW-1:0]      waddr_q, qaddr_q, rd_addr_q, row_base_q, start_addr, rd_next, base_next;
	logic [11:0]         orow_q;
	logic [WIDTH_W-1:0]  ocol_q;
	logic [RC_W-1:0]     nrows_q, ncols_q, rowc_q, colc_q;
	logic [7:0]          row_store [STORE];
	logic [7:0]          rs_data_s1;
	logic                rd_v_s1;
	logic                in_acc, pre, st_wr, out_load, frame_last, col_last, out_valid_q;
	logic [7:0]          med_q;
	logic [11:0]         row_q;
	logic [7:0]          col_q;
	logic                fend_q;
	sel_ctrl_t           sel_ctrl;
	sel_stat_t           sel_stat;
	logic [7:0]          sel_median;

	always_comb begin
		if (width_q == '0)
			w_eff = 9'd1;
		else if (int'(width_q) > MAX_WIDTH)
			w_eff = WIDTH_W'(MAX_WIDTH);
		else
			w_eff = width_q;
		if (height_q == '0)
			h_eff = 13'd1;
		else if (int'(height_q) > MAX_HEIGHT)
			h_eff = HEIGHT_W'(MAX_HEIGHT);
		else
			h_eff = height_q;
		r_eff = (int'(radius_q) > MAX_RADIUS) ? RADIUS_W'(MAX_RADIUS) : radius_q;
		npix  = POS_W'(w_eff) * POS_W'(h_eff);
		lag   = POS_W'(r_eff) * POS_W'(w_eff) + POS_W'(r_eff);
	end

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign pre      = pos_q < npix;
	assign st_wr    = in_acc && pre && !func;

	// Clipped extent of the window around the output position.
	always_comb begin
		int off_i;
		int start_i;
		int nb_i;
		up      = (int'(orow_q) < int'(r_eff)) ? orow_q[1:0] : r_eff;
		dn_room = h_eff - 13'd1 - {1'b0, orow_q};
		dn      = (int'(dn_room) < int'(r_eff)) ? dn_room[1:0] : r_eff;
		lf      = (int'(ocol_q) < int'(r_eff)) ? ocol_q[1:0] : r_eff;
		rt_room = w_eff - 9'd1 - ocol_q;
		rt      = (int'(rt_room) < int'(r_eff)) ? rt_room[1:0] : r_eff;
		off_i   = int'(up) * int'(w_eff) + int'(lf);
		start_i = int'(qaddr_q) - off_i;
		if (start_i < 0)
			start_i = start_i + STORE;
		start_addr = SAW'(start_i);
		nb_i = int'(row_base_q) + int'(w_eff);
		if (nb_i >= STORE)
			nb_i = nb_i - STORE;
		base_next = SAW'(nb_i);
		rd_next   = (rd_addr_q == SAW'(STORE - 1)) ? '0 : rd_addr_q + 1'b1;
	end

	assign col_last   = (ocol_q == w_eff - 9'd1);
	assign frame_last = ({1'b0, orow_q} == h_eff - 13'd1) && col_last;
	assign out_load   = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk) begin
		if (st_wr)
			row_store[waddr_q] <= pixel_in;
		rs_data_s1 <= row_store[rd_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			width_q     <= WIDTH_RST;
			height_q    <= HEIGHT_RST;
			radius_q    <= RADIUS_RST;
			pos_q       <= '0;
			waddr_q     <= '0;
			qaddr_q     <= '0;
			orow_q      <= '0;
			ocol_q      <= '0;
			rd_addr_q   <= '0;
			row_base_q  <= '0;
			nrows_q     <= '0;
			ncols_q     <= '0;
			rowc_q      <= '0;
			colc_q      <= '0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == ST_GATHER);
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (cfg_we && (cfg_addr == CFG_WIDTH || cfg_addr == CFG_HEIGHT
					|| cfg_addr == CFG_RADIUS)) begin
				unique case (cfg_addr)
					CFG_WIDTH:  width_q  <= cfg_data[WIDTH_W-1:0];
					CFG_HEIGHT: height_q <= cfg_data[HEIGHT_W-1:0];
					default:    radius_q <= cfg_data[RADIUS_W-1:0];
				endcase
				pos_q   <= '0;
				waddr_q <= '0;
				qaddr_q <= '0;
				orow_q  <= '0;
				ocol_q  <= '0;
			end else begin
				unique case (state_q)
					ST_IDLE: begin
						if (in_acc && !(pre && func)) begin
							if (pre)
								waddr_q <= (waddr_q == SAW'(STORE - 1)) ? '0 : waddr_q + 1'b1;
							pos_q <= pos_q + 1'b1;
							if (pos_q >= lag)
								state_q <= ST_SETUP;
						end
					end
					ST_SETUP: begin
						nrows_q    <= RC_W'(up) + RC_W'(dn) + 3'd1;
						ncols_q    <= RC_W'(lf) + RC_W'(rt) + 3'd1;
						rd_addr_q  <= start_addr;
						row_base_q <= start_addr;
						rowc_q     <= '0;
						colc_q     <= '0;
						state_q    <= ST_GATHER;
					end
					ST_GATHER: begin
						if (colc_q == ncols_q - 3'd1) begin
							colc_q <= '0;
							if (rowc_q == nrows_q - 3'd1) begin
								state_q <= ST_GWAIT;
							end else begin
								rowc_q     <= rowc_q + 3'd1;
								row_base_q <= base_next;
								rd_addr_q  <= base_next;
							end
						end else begin
							colc_q    <= colc_q + 3'd1;
							rd_addr_q <= rd_next;
						end
					end
					ST_GWAIT: state_q <= ST_START;
					ST_START: state_q <= ST_SEL;
					ST_SEL: begin
						if (sel_stat.done)
							state_q <= ST_OUT;
					end
					ST_OUT: begin
						if (out_load) begin
							state_q <= ST_IDLE;
							if (frame_last) begin
								pos_q   <= '0;
								waddr_q <= '0;
								qaddr_q <= '0;
								orow_q  <= '0;
								ocol_q  <= '0;
							end else begin
								qaddr_q <= (qaddr_q == SAW'(STORE - 1)) ? '0 : qaddr_q + 1'b1;
								if (col_last) begin
									ocol_q <= '0;
									orow_q <= orow_q + 12'd1;
								end else begin
									ocol_q <= ocol_q + 9'd1;
								end
							end
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			med_q  <= sel_median;
			row_q  <= orow_q;
			col_q  <= ocol_q[7:0];
			fend_q <= frame_last;
		end
	end

	assign sel_ctrl.load  = rd_v_s1;
	assign sel_ctrl.start = (state_q == ST_START);

	cwmf_select #(
		.MAX_RADIUS(MAX_RADIUS)
	) u_select (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (sel_ctrl),
		.load_data(rs_data_s1),
		.stat     (sel_stat),
		.median   (sel_median)
	);

	assign out_valid    = out_valid_q;
	assign median_pixel = med_q;
	assign out_row      = row_q;
	assign out_col      = col_q;
	assign frame_end    = fend_q;

	`CWMF_ASSERT(a_done_in_sel, sel_stat.done |-> (state_q == ST_SEL), "done outside select")
	`CWMF_ASSERT(a_frame_restart, (out_load && frame_last) |=> (pos_q == '0), "no restart")
	`CWMF_ASSERT_NR(a_addr_range, (state_q == ST_GATHER) |-> (int'(rd_addr_q) < STORE), "bad addr")
	`CWMF_ASSERT(a_sel_idle_at_start, sel_ctrl.start |-> !sel_stat.busy, "select busy at start")
endmodule
`default_nettype wire
